/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/lebf_pkg.sv */
// ---------------------------------------------------------------------------
// lebf_pkg
// Types and constants of the Lisp expression boundary finder.
// ---------------------------------------------------------------------------
`default_nettype none

package lebf_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned LEN_W   = 14;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned NEST_W  = 8;

  localparam logic [LEN_W-1:0]   MAX_LEN   = 14'd8192;
  localparam logic [NEST_W-1:0]  MAX_NEST  = 8'd255;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_DATA = 2'd0;
  localparam logic [OP_W-1:0] OP_INTR = 2'd1;
  localparam logic [OP_W-1:0] OP_EOF  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_BAR    = 8'h7C;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_HASH   = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4,
    MODE_BBAR   = 3'd5,
    MODE_BHASH  = 3'd6
  } scan_mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CONT = 3'd0,
    ST_DONE = 3'd1,
    ST_EOF  = 3'd2,
    ST_OVF  = 3'd3,
    ST_INTR = 3'd4
  } status_t;

  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    status_t           status;
    logic [LEN_W-1:0]  len;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/lebf_in_stage.sv */
// ---------------------------------------------------------------------------
// lebf_in_stage
// Input register: holds one transaction until the scan stage takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module lebf_in_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [lebf_pkg::OP_W-1:0]   in_op_kind,
  input  wire logic [lebf_pkg::BYTE_W-1:0] in_byte_in,
  input  wire logic                       advance,
  output lebf_pkg::item_t                 item
);

  logic                       valid_r, valid_nxt;
  logic [lebf_pkg::OP_W-1:0]   op_r;
  logic [lebf_pkg::BYTE_W-1:0] data_r;
  logic                       load;

  assign load      = !valid_r || advance;
  // nothing is taken while reset is held
  assign in_stall  = !load || !rst_n;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      op_r   <= in_op_kind;
      data_r <= in_byte_in;
    end
  end

  assign item.valid = valid_r;
  assign item.op    = op_r;
  assign item.data  = data_r;

endmodule

`default_nettype wire

/* rtl/core/lebf_scan.sv */
// ---------------------------------------------------------------------------
// lebf_scan
// Scan state (mode, paren depth, comment nesting, length) and the
// per-byte update that classifies each transaction.
// ---------------------------------------------------------------------------
`default_nettype none

module lebf_scan (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire lebf_pkg::item_t item,
  input  wire logic         advance,
  output lebf_pkg::result_t res
);

  lebf_pkg::scan_mode_t              mode_r, mode_nxt;
  logic [lebf_pkg::DEPTH_W-1:0]       depth_r, depth_nxt;
  logic [lebf_pkg::NEST_W-1:0]        nest_r, nest_nxt;
  logic [lebf_pkg::LEN_W-1:0]         count_r, count_nxt;
  logic [lebf_pkg::LEN_W-1:0]         cnt;
  logic                              done;
  logic                              fire;

  assign fire = item.valid && advance;
  assign cnt  = count_r + 1'b1;

  // Mode, depth and nesting update for a data byte.
  always_comb begin
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    nest_nxt  = nest_r;
    done      = 1'b0;
    case (mode_r)
      lebf_pkg::MODE_NORMAL: begin
        if (item.data == lebf_pkg::CH_NL) begin
          done = (depth_r == '0);
        end else if (item.data == lebf_pkg::CH_LPAREN) begin
          if (depth_r != lebf_pkg::DEPTH_MAX) depth_nxt = depth_r + 1'b1;
        end else if (item.data == lebf_pkg::CH_RPAREN) begin
          if (depth_r <= lebf_pkg::DEPTH_W'(1)) done = 1'b1;
          else depth_nxt = depth_r - 1'b1;
        end else if (item.data == lebf_pkg::CH_SEMI) begin
          mode_nxt = lebf_pkg::MODE_LINE;
        end else if (item.data == lebf_pkg::CH_HASH) begin
          mode_nxt = lebf_pkg::MODE_HASH;
        end
      end
      lebf_pkg::MODE_HASH: begin
        mode_nxt = lebf_pkg::MODE_NORMAL;
        if (item.data == lebf_pkg::CH_LPAREN) begin
          if (depth_r != lebf_pkg::DEPTH_MAX) depth_nxt = depth_r + 1'b1;
        end else if (item.data == lebf_pkg::CH_BAR) begin
          nest_nxt = lebf_pkg::NEST_W'(1);
          mode_nxt = lebf_pkg::MODE_BLOCK;
        end else if (item.data == lebf_pkg::CH_BSLASH) begin
          mode_nxt = lebf_pkg::MODE_ESC;
        end
      end
      lebf_pkg::MODE_ESC: begin
        mode_nxt = lebf_pkg::MODE_NORMAL;
      end
      lebf_pkg::MODE_LINE: begin
        if (item.data == lebf_pkg::CH_NL) mode_nxt = lebf_pkg::MODE_NORMAL;
      end
      lebf_pkg::MODE_BLOCK: begin
        if (item.data == lebf_pkg::CH_BAR) mode_nxt = lebf_pkg::MODE_BBAR;
        else if (item.data == lebf_pkg::CH_HASH) mode_nxt = lebf_pkg::MODE_BHASH;
      end
      lebf_pkg::MODE_BBAR: begin
        mode_nxt = lebf_pkg::MODE_BLOCK;
        if (item.data == lebf_pkg::CH_HASH) begin
          if (nest_r <= lebf_pkg::NEST_W'(1)) begin
            nest_nxt = '0;
            mode_nxt = lebf_pkg::MODE_NORMAL;
          end else begin
            nest_nxt = nest_r - 1'b1;
          end
        end
      end
      lebf_pkg::MODE_BHASH: begin
        mode_nxt = lebf_pkg::MODE_BLOCK;
        if (item.data == lebf_pkg::CH_BAR && nest_r < lebf_pkg::MAX_NEST) begin
          nest_nxt = nest_r + 1'b1;
        end
      end
      default: begin
        mode_nxt = lebf_pkg::MODE_NORMAL;
      end
    endcase
  end

  // Result and the state that the transaction leaves behind.
  lebf_pkg::scan_mode_t        st_mode;
  logic [lebf_pkg::DEPTH_W-1:0] st_depth;
  logic [lebf_pkg::NEST_W-1:0]  st_nest;
  logic [lebf_pkg::LEN_W-1:0]   st_count;

  always_comb begin
    st_mode    = lebf_pkg::MODE_NORMAL;
    st_depth   = '0;
    st_nest    = '0;
    st_count   = '0;
    res.valid  = 1'b1;
    res.data   = '0;
    res.status = lebf_pkg::ST_CONT;
    res.len    = '0;
    case (item.op)
      lebf_pkg::OP_INTR: begin
        res.status = lebf_pkg::ST_INTR;
      end
      lebf_pkg::OP_EOF: begin
        if (count_r >= lebf_pkg::MAX_LEN) begin
          res.status = lebf_pkg::ST_OVF;
        end else begin
          res.status = lebf_pkg::ST_EOF;
          res.len    = count_r;
        end
      end
      lebf_pkg::OP_DATA: begin
        if (count_r >= lebf_pkg::MAX_LEN) begin
          res.status = lebf_pkg::ST_OVF;
        end else if (done) begin
          // terminator needs a free slot
          if (cnt >= lebf_pkg::MAX_LEN) begin
            res.status = lebf_pkg::ST_OVF;
          end else begin
            res.status = lebf_pkg::ST_DONE;
            res.data   = item.data;
            res.len    = cnt;
          end
        end else begin
          st_mode    = mode_nxt;
          st_depth   = depth_nxt;
          st_nest    = nest_nxt;
          st_count   = cnt;
          res.data   = item.data;
          res.len    = cnt;
        end
      end
      default: begin
        // reserved op: no result, state untouched
        res.valid = 1'b0;
        st_mode   = mode_r;
        st_depth  = depth_r;
        st_nest   = nest_r;
        st_count  = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lebf_pkg::MODE_NORMAL;
      depth_r <= '0;
      nest_r  <= '0;
      count_r <= '0;
    end else if (fire) begin
      mode_r  <= st_mode;
      depth_r <= st_depth;
      nest_r  <= st_nest;
      count_r <= st_count;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lebf_out_stage.sv */
// ---------------------------------------------------------------------------
// lebf_out_stage
// Result register: holds one result until the consumer takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module lebf_out_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        item_valid,
  input  wire lebf_pkg::result_t           res,
  output logic                             advance,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lebf_pkg::BYTE_W-1:0]       out_byte_out,
  output logic [lebf_pkg::STAT_W-1:0]       out_status,
  output logic [lebf_pkg::LEN_W-1:0]        out_expr_length
);

  logic                       valid_r, valid_nxt;
  logic [lebf_pkg::BYTE_W-1:0] data_r;
  lebf_pkg::status_t          status_r;
  logic [lebf_pkg::LEN_W-1:0]  len_r;
  logic                       load;

  assign advance   = !valid_r || !out_stall;
  assign load      = advance && item_valid && res.valid;
  assign valid_nxt = advance ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r   <= res.data;
      status_r <= res.status;
      len_r    <= res.len;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte_out    = data_r;
  assign out_status      = status_r;
  assign out_expr_length = len_r;

endmodule

`default_nettype wire

/* rtl/core/lisp_expression_boundary_finder.sv */
// ---------------------------------------------------------------------------
// lisp_expression_boundary_finder
// Finds the end of each Lisp top-level expression in a console byte stream.
// ---------------------------------------------------------------------------
//  Channel  Ports                                  Direction  Moves
//  in       in_valid/in_stall, in_op_kind, in_byte_in      in         op + byte
//  out      out_valid/out_stall, out_byte_out,
//           out_status, out_expr_length                   out        echo + status
//
//  One transaction per cycle sustained while out_stall is low; an accepted
//  transaction passes the input register, scan update and result register.
//  The scan state updates in the cycle a transaction moves to the result
//  register, so the next byte sees it at once.
//  rst_n is synchronous, active low; it clears the scan state and both
//  valid flags, and holds in_stall high. out_stall backs up into in_stall
//  in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module lisp_expression_boundary_finder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [lebf_pkg::OP_W-1:0]    in_op_kind,
  input  wire logic [lebf_pkg::BYTE_W-1:0]  in_byte_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [lebf_pkg::BYTE_W-1:0]       out_byte_out,
  output logic [lebf_pkg::STAT_W-1:0]       out_status,
  output logic [lebf_pkg::LEN_W-1:0]        out_expr_length
);

  lebf_pkg::item_t   item;
  lebf_pkg::result_t res;
  logic              advance;

  lebf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op_kind (in_op_kind),
    .in_byte_in (in_byte_in),
    .advance    (advance),
    .item       (item)
  );

  lebf_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .res     (res)
  );

  lebf_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .res             (res),
    .advance         (advance),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte_out    (out_byte_out),
    .out_status      (out_status),
    .out_expr_length (out_expr_length)
  );

endmodule

`default_nettype wire

/* rtl/core/lebf_checker.sv */
// ---------------------------------------------------------------------------
// lebf_checker
// Port-level checks of the expression boundary finder.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lebf_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [lebf_pkg::BYTE_W-1:0]  out_byte_out,
  input wire logic [lebf_pkg::STAT_W-1:0]  out_status,
  input wire logic [lebf_pkg::LEN_W-1:0]   out_expr_length
);

  logic is_drop, is_done, is_cont;

  assign is_drop = out_status == lebf_pkg::ST_OVF || out_status == lebf_pkg::ST_INTR;
  assign is_done = out_status == lebf_pkg::ST_DONE;
  assign is_cont = out_status == lebf_pkg::ST_CONT;

  `ASSERT_NEXT_ALWAYS(a_rst_clears_out, clk, !rst_n, !out_valid)

  `ASSERT_IMPLY(a_drop_is_empty, clk, rst_n, out_valid && is_drop, out_expr_length == '0 && out_byte_out == '0)

  `ASSERT_IMPLY(a_done_on_close, clk, rst_n, out_valid && is_done, out_expr_length != '0 && (out_byte_out == lebf_pkg::CH_RPAREN || out_byte_out == lebf_pkg::CH_NL))

  `ASSERT_IMPLY(a_cont_has_length, clk, rst_n, out_valid && is_cont, out_expr_length != '0)

  `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_expr_length))

endmodule

bind lisp_expression_boundary_finder lebf_checker u_lebf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte_out    (out_byte_out),
  .out_status      (out_status),
  .out_expr_length (out_expr_length)
);

`default_nettype wire
